// File: rtl/tdbe_pkg.sv
// Shared types and constants for the tilt to d-pad button event block.
// No dependencies; every other file in rtl/ depends on this package.
package tdbe_pkg;

	// Event codes carried on the result channel
	typedef enum logic [2:0] {
		EV_PRESS   = 3'd0,
		EV_SHORT   = 3'd1,
		EV_LONG    = 3'd2,
		EV_REPEAT  = 3'd3,
		EV_RELEASE = 3'd4
	} ev_kind_t;

	// Button phase; the top bit set means long or repeat
	typedef enum logic [1:0] {
		PH_REL  = 2'd0,
		PH_PRS  = 2'd1,
		PH_LONG = 2'd2,
		PH_RPT  = 2'd3
	} ph_t;

	// Button codes
	localparam logic [1:0] BTN_UP    = 2'd0;
	localparam logic [1:0] BTN_DOWN  = 2'd1;
	localparam logic [1:0] BTN_LEFT  = 2'd2;
	localparam logic [1:0] BTN_RIGHT = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_UP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_DOWN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_BAND  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LEFT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_RGT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_BAND = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MS  = 3'd7;

	// Hold timer settings are fixed at 16 bits
	localparam int HOLD_W = 16;

	// Event slots: four per axis, or two per button on release all
	localparam int NSLOT = 8;

	typedef struct packed {
		logic     vld;
		ev_kind_t kind;
		logic [1:0] btn;
	} ev_t;

	// Result channel data byte holds the button code
	localparam int OUT_DATA_W = 8;

endpackage

// File: rtl/tdbe_cfg.sv
// Configuration register bank for the tilt to d-pad block.
// Depends on tdbe_pkg for register indexes.
module tdbe_cfg #(
	parameter int ANGLE_BITS = 13,
	parameter int CFG_W      = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tdbe_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]                 cfg_wdata,
	output logic signed [ANGLE_BITS-1:0]     roll_up_q,
	output logic signed [ANGLE_BITS-1:0]     roll_dn_q,
	output logic [ANGLE_BITS-2:0]            roll_band_q,
	output logic signed [ANGLE_BITS-1:0]     pitch_lf_q,
	output logic signed [ANGLE_BITS-1:0]     pitch_rt_q,
	output logic [ANGLE_BITS-2:0]            pitch_band_q,
	output logic [tdbe_pkg::HOLD_W-1:0]      long_ms_q,
	output logic [tdbe_pkg::HOLD_W-1:0]      rep_ms_q
);
	import tdbe_pkg::*;

	// Register writes, decoded by index; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_up_q    <= ANGLE_BITS'(128);
			roll_dn_q    <= ANGLE_BITS'(-128);
			roll_band_q  <= (ANGLE_BITS-1)'(48);
			pitch_lf_q   <= ANGLE_BITS'(320);
			pitch_rt_q   <= ANGLE_BITS'(-320);
			pitch_band_q <= (ANGLE_BITS-1)'(80);
			long_ms_q    <= HOLD_W'(300);
			rep_ms_q     <= HOLD_W'(150);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ROLL_UP:    roll_up_q    <= cfg_wdata[ANGLE_BITS-1:0];
				CFG_ROLL_DOWN:  roll_dn_q    <= cfg_wdata[ANGLE_BITS-1:0];
				CFG_ROLL_BAND:  roll_band_q  <= cfg_wdata[ANGLE_BITS-2:0];
				CFG_PITCH_LEFT: pitch_lf_q   <= cfg_wdata[ANGLE_BITS-1:0];
				CFG_PITCH_RGT:  pitch_rt_q   <= cfg_wdata[ANGLE_BITS-1:0];
				CFG_PITCH_BAND: pitch_band_q <= cfg_wdata[ANGLE_BITS-2:0];
				CFG_LONG_MS:    long_ms_q    <= cfg_wdata[HOLD_W-1:0];
				CFG_REPEAT_MS:  rep_ms_q     <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/tdbe_axis.sv
// One tilt axis: threshold, hysteresis and hold timing for a button pair.
// Depends on tdbe_pkg for event and phase types.
module tdbe_axis #(
	parameter int ANGLE_BITS = 13,
	parameter int TIME_BITS  = 32
) (
	input  logic                          en,
	input  logic [1:0]                    btn_hi,
	input  logic signed [ANGLE_BITS-1:0]  angle,
	input  logic signed [ANGLE_BITS-1:0]  thr_hi,
	input  logic signed [ANGLE_BITS-1:0]  thr_lo,
	input  logic [ANGLE_BITS-2:0]         band,
	input  logic [tdbe_pkg::HOLD_W-1:0]   long_ms,
	input  logic [tdbe_pkg::HOLD_W-1:0]   rep_ms,
	input  logic [TIME_BITS-1:0]          now,
	input  tdbe_pkg::ph_t                 ph_hi,
	input  tdbe_pkg::ph_t                 ph_lo,
	input  logic [TIME_BITS-1:0]          st_hi,
	input  logic [TIME_BITS-1:0]          st_lo,
	output tdbe_pkg::ev_t [3:0]           ev,
	output tdbe_pkg::ph_t                 ph_hi_nx,
	output tdbe_pkg::ph_t                 ph_lo_nx,
	output logic [TIME_BITS-1:0]          st_hi_nx,
	output logic [TIME_BITS-1:0]          st_lo_nx
);
	import tdbe_pkg::*;

	localparam int W = ANGLE_BITS + 2;

	logic signed [W-1:0] a_x, hi_x, lo_x, band_x, hi_m, lo_p;
	logic a_gt, a_lt, in_band, sel_lo;
	ph_t  ph_b, ph_o;
	logic [TIME_BITS-1:0] st_b, dur, long_x, rep_x;
	logic do_long, do_rep;
	logic [1:0] btn_b, btn_o, btn_lo;

	// Threshold and release band compares at a width that cannot overflow
	assign a_x     = W'(angle);
	assign hi_x    = W'(thr_hi);
	assign lo_x    = W'(thr_lo);
	assign band_x  = $signed(W'(band));
	assign hi_m    = hi_x - band_x;
	assign lo_p    = lo_x + band_x;
	assign a_gt    = a_x > hi_x;
	assign a_lt    = a_x < lo_x;
	assign in_band = (a_x < hi_m) && (a_x > lo_p);
	assign sel_lo  = !a_gt && a_lt;

	// Held button and its partner
	assign btn_lo = {btn_hi[1], 1'b1};
	assign btn_b  = {btn_hi[1], sel_lo};
	assign btn_o  = {btn_hi[1], !sel_lo};
	assign ph_b   = sel_lo ? ph_lo : ph_hi;
	assign ph_o   = sel_lo ? ph_hi : ph_lo;
	assign st_b   = sel_lo ? st_lo : st_hi;

	// Hold timing, durations modulo the timestamp width
	assign dur     = now - st_b;
	assign long_x  = TIME_BITS'(long_ms);
	assign rep_x   = TIME_BITS'(rep_ms);
	assign do_long = (long_ms != '0) && (ph_b == PH_PRS) && (dur >= long_x);
	assign do_rep  = !do_long && (rep_ms != '0) && ph_b[1] && (dur > rep_x);

	// Event slots in emission order and next phase of both buttons
	always_comb begin
		ev       = '0;
		ph_hi_nx = ph_hi;
		ph_lo_nx = ph_lo;
		st_hi_nx = st_hi;
		st_lo_nx = st_lo;
		if (en && (a_gt || a_lt)) begin
			if (ph_b != PH_REL) begin
				if (do_long || do_rep) begin
					ev[0] = '{vld: 1'b1, kind: ev_kind_t'(do_long ? EV_LONG : EV_REPEAT),
						btn: btn_b};
					if (sel_lo) begin
						ph_lo_nx = ph_t'(do_long ? PH_LONG : PH_RPT);
						st_lo_nx = now;
					end else begin
						ph_hi_nx = ph_t'(do_long ? PH_LONG : PH_RPT);
						st_hi_nx = now;
					end
				end
			end else begin
				// new press releases the partner first
				ev[0] = '{vld: (ph_o == PH_PRS), kind: EV_SHORT, btn: btn_o};
				ev[1] = '{vld: (ph_o != PH_REL), kind: EV_RELEASE, btn: btn_o};
				ev[2] = '{vld: 1'b1, kind: EV_PRESS, btn: btn_b};
				if (sel_lo) begin
					ph_lo_nx = PH_PRS;
					st_lo_nx = now;
					ph_hi_nx = PH_REL;
					st_hi_nx = '0;
				end else begin
					ph_hi_nx = PH_PRS;
					st_hi_nx = now;
					ph_lo_nx = PH_REL;
					st_lo_nx = '0;
				end
			end
		end else if (en && in_band) begin
			ev[0] = '{vld: (ph_hi == PH_PRS), kind: EV_SHORT, btn: btn_hi};
			ev[1] = '{vld: (ph_hi != PH_REL), kind: EV_RELEASE, btn: btn_hi};
			ev[2] = '{vld: (ph_lo == PH_PRS), kind: EV_SHORT, btn: btn_lo};
			ev[3] = '{vld: (ph_lo != PH_REL), kind: EV_RELEASE, btn: btn_lo};
			ph_hi_nx = PH_REL;
			ph_lo_nx = PH_REL;
			st_hi_nx = '0;
			st_lo_nx = '0;
		end
	end

endmodule

// File: rtl/tdbe_evq.sv
// Result register: holds the event slots of one request and drains them in order.
// Depends on tdbe_pkg for the event slot type.
module tdbe_evq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  tdbe_pkg::ev_t [tdbe_pkg::NSLOT-1:0] slots,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [tdbe_pkg::OUT_DATA_W-1:0]     m_tdata,  // [1:0] button, rest zero
	output logic [2:0]                          m_tuser,  // [2:0] event_kind
	output logic                                m_tlast,
	output logic                                free
);
	import tdbe_pkg::*;

	ev_t [NSLOT-1:0] slot_q;
	logic [NSLOT-1:0] mask_q, mask_new, mask_rest;
	logic [$clog2(NSLOT)-1:0] sel;
	logic hs;

	// Lowest pending slot goes out first
	always_comb begin
		sel = '0;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (mask_q[i]) sel = ($clog2(NSLOT))'(i);
		end
	end

	always_comb begin
		for (int i = 0; i < NSLOT; i++) mask_new[i] = slots[i].vld;
	end

	assign mask_rest = mask_q & (mask_q - NSLOT'(1));
	assign m_tvalid  = |mask_q;
	assign m_tlast   = (mask_rest == '0);
	assign m_tdata   = OUT_DATA_W'(slot_q[sel].btn);
	assign m_tuser   = slot_q[sel].kind;
	assign hs        = m_tvalid && m_tready;
	assign free      = !m_tvalid || (hs && m_tlast);

	// Pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= mask_new;
		end else if (hs) begin
			mask_q <= mask_rest;
		end
	end

	// Slot payload
	always_ff @(posedge clk) begin
		if (load) slot_q <= slots;
	end

endmodule

// File: rtl/tilt_to_dpad_button_events_top.sv
// Top level of the tilt to d-pad button event block.
// Depends on tdbe_pkg, tdbe_cfg, tdbe_axis and tdbe_evq.
//
// Input channel s_*: one request per orientation sample or command.
//   s_tuser[0] func (1 = release all), s_tuser[1] sensor_present,
//   s_tdata roll_angle, pitch_angle, now_ms from the lowest bit up.
// Output channel m_*: one button event per transfer; m_tuser is the
//   event kind, m_tdata[1:0] the button, m_tlast marks the final event
//   of a request. Requests that cause no event produce no transfer.
// Config port: cfg_we, cfg_idx, cfg_wdata; write only while idle.
// A request is registered on acceptance and evaluated in one pass against
// the button state while it waits in the input register; its events (up to
// six) load into the result register once that register is free and drain
// one per cycle while m_tready is high. The next request is evaluated in
// the cycle its predecessor's last event is taken. When m_tready is low
// the events hold, the input register fills and s_tready drops.
// Reset clears all buttons to released, timers to zero and the
// configuration to its defaults.
module tilt_to_dpad_button_events_top #(
	parameter int ANGLE_BITS = 13,
	parameter int TIME_BITS  = 32,
	localparam int IN_W  = ((2 * ANGLE_BITS + TIME_BITS + 7) / 8) * 8,
	localparam int CFG_W = (ANGLE_BITS > 16) ? ANGLE_BITS : 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [IN_W-1:0]                   s_tdata,  // roll_angle, pitch_angle, now_ms
	input  logic [1:0]                        s_tuser,  // func, sensor_present
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tdbe_pkg::OUT_DATA_W-1:0]   m_tdata,  // button, zero fill
	output logic [2:0]                        m_tuser,  // event_kind
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [tdbe_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_W-1:0]                  cfg_wdata
);
	import tdbe_pkg::*;

	logic signed [ANGLE_BITS-1:0] roll_up_q, roll_dn_q, pitch_lf_q, pitch_rt_q;
	logic [ANGLE_BITS-2:0] roll_band_q, pitch_band_q;
	logic [HOLD_W-1:0] long_ms_q, rep_ms_q;

	logic valid_s1, func_s1, pres_s1;
	logic signed [ANGLE_BITS-1:0] roll_s1, pitch_s1;
	logic [TIME_BITS-1:0] now_s1;

	ph_t ph_q [4];
	logic [TIME_BITS-1:0] st_q [4];
	ph_t ph_nx [4];
	logic [TIME_BITS-1:0] st_nx [4];

	ev_t [3:0] ev_roll, ev_pitch;
	ev_t [NSLOT-1:0] slots;
	logic axis_en, take, free;

	tdbe_cfg #(.ANGLE_BITS(ANGLE_BITS), .CFG_W(CFG_W)) u_cfg (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_wdata,
		.roll_up_q, .roll_dn_q, .roll_band_q,
		.pitch_lf_q, .pitch_rt_q, .pitch_band_q,
		.long_ms_q, .rep_ms_q
	);

	// Input register
	assign take     = valid_s1 && free;
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= s_tuser[0];
			pres_s1  <= s_tuser[1];
			roll_s1  <= s_tdata[ANGLE_BITS-1:0];
			pitch_s1 <= s_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
			now_s1   <= s_tdata[2*ANGLE_BITS+TIME_BITS-1:2*ANGLE_BITS];
		end
	end

	// Axis evaluation
	assign axis_en = pres_s1 && !func_s1;

	tdbe_axis #(.ANGLE_BITS(ANGLE_BITS), .TIME_BITS(TIME_BITS)) u_roll (
		.en(axis_en), .btn_hi(BTN_UP), .angle(roll_s1),
		.thr_hi(roll_up_q), .thr_lo(roll_dn_q), .band(roll_band_q),
		.long_ms(long_ms_q), .rep_ms(rep_ms_q), .now(now_s1),
		.ph_hi(ph_q[0]), .ph_lo(ph_q[1]), .st_hi(st_q[0]), .st_lo(st_q[1]),
		.ev(ev_roll),
		.ph_hi_nx(ph_nx[0]), .ph_lo_nx(ph_nx[1]),
		.st_hi_nx(st_nx[0]), .st_lo_nx(st_nx[1])
	);

	tdbe_axis #(.ANGLE_BITS(ANGLE_BITS), .TIME_BITS(TIME_BITS)) u_pitch (
		.en(axis_en), .btn_hi(BTN_LEFT), .angle(pitch_s1),
		.thr_hi(pitch_lf_q), .thr_lo(pitch_rt_q), .band(pitch_band_q),
		.long_ms(long_ms_q), .rep_ms(rep_ms_q), .now(now_s1),
		.ph_hi(ph_q[2]), .ph_lo(ph_q[3]), .st_hi(st_q[2]), .st_lo(st_q[3]),
		.ev(ev_pitch),
		.ph_hi_nx(ph_nx[2]), .ph_lo_nx(ph_nx[3]),
		.st_hi_nx(st_nx[2]), .st_lo_nx(st_nx[3])
	);

	// Event slots: release all uses short/release per button in order
	always_comb begin
		if (func_s1) begin
			for (int b = 0; b < 4; b++) begin
				slots[2*b]   = '{vld: (ph_q[b] == PH_PRS), kind: EV_SHORT, btn: 2'(b)};
				slots[2*b+1] = '{vld: (ph_q[b] != PH_REL), kind: EV_RELEASE, btn: 2'(b)};
			end
		end else begin
			slots = {ev_pitch, ev_roll};
		end
	end

	// Button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 4; b++) begin
				ph_q[b] <= PH_REL;
				st_q[b] <= '0;
			end
		end else if (take) begin
			for (int b = 0; b < 4; b++) begin
				ph_q[b] <= ph_t'(func_s1 ? PH_REL : ph_nx[b]);
				st_q[b] <= func_s1 ? '0 : st_nx[b];
			end
		end
	end

	tdbe_evq u_evq (
		.clk, .arst_n, .load(take), .slots, .m_tready,
		.m_tvalid, .m_tdata, .m_tuser, .m_tlast, .free
	);

endmodule

// File: rtl/tdbe_chk.sv
// Port-level checker for the tilt to d-pad block, bound to the top level.
// Depends on tdbe_pkg for port widths.
module tdbe_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [tdbe_pkg::OUT_DATA_W-1:0]   m_tdata,
	input logic [2:0]                        m_tuser,
	input logic                              m_tlast
);
	logic s_hs;
	assign s_hs = s_tvalid && s_tready;

	// A stalled event holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled event changed");

	// Input only stalls while events are waiting
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending event");

	// Events of one request go out without gaps
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside an event burst");

	// No events appear without a request
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && !s_hs) ##1 (!m_tvalid && !s_hs) |=> !m_tvalid)
		else $error("event without a request");

endmodule

bind tilt_to_dpad_button_events_top tdbe_chk u_tdbe_chk (.*);

// File: sim/tilt_to_dpad_button_events_top_tb.sv
// Self-checking testbench for tilt_to_dpad_button_events_top: directed and random tilt samples,
// a local event predictor, and a scoreboard on the event stream.
// Depends on rtl/tdbe_pkg.sv and the RTL under rtl/.
`timescale 1ns / 1ps

module tilt_to_dpad_button_events_top_tb;
	import tdbe_pkg::*;

	localparam int ANGLE_MAX = 2880;

	typedef struct {
		logic               func;
		logic               present;
		logic signed [12:0] roll;
		logic signed [12:0] pitch;
		logic [31:0]        now;
	} tilt_req_t;

	typedef struct {
		ev_kind_t   kind;
		logic [1:0] btn;
		logic       last;
	} button_event_t;

	// DUT ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [15:0] cfg_wdata = '0;

	tilt_to_dpad_button_events_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Clock: 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor copy of the configuration
	logic signed [12:0] roll_up_thr    = 13'sd128;
	logic signed [12:0] roll_down_thr  = -13'sd128;
	logic [11:0]        roll_band      = 12'd48;
	logic signed [12:0] pitch_left_thr = 13'sd320;
	logic signed [12:0] pitch_rgt_thr  = -13'sd320;
	logic [11:0]        pitch_band     = 12'd80;
	logic [15:0]        long_ms        = 16'd300;
	logic [15:0]        repeat_ms      = 16'd150;

	// Predictor copy of the button state
	ph_t         btn_phase [4] = '{PH_REL, PH_REL, PH_REL, PH_REL};
	logic [31:0] btn_since [4] = '{32'd0, 32'd0, 32'd0, 32'd0};

	tilt_req_t     pending_requests [$];
	button_event_t expected_events [$];
	button_event_t event_batch [$];

	int src_idle_pct = 29;
	int snk_idle_pct = 29;
	int mismatch_count = 0;
	int hold_cnt;
	logic hold_kick = 1'b0;

	// Random stimulus state
	logic [31:0] gen_now;
	int roll_region = 0;
	int pitch_region = 0;

	function automatic void add_event(input ev_kind_t kind, input logic [1:0] b);
		button_event_t e;
		e.kind = kind;
		e.btn = b;
		e.last = 1'b0;
		event_batch.push_back(e);
	endfunction

	function automatic void release_button(input logic [1:0] b);
		if (btn_phase[b] == PH_REL)
			return;
		if (btn_phase[b] == PH_PRS)
			add_event(EV_SHORT, b);
		add_event(EV_RELEASE, b);
		btn_phase[b] = PH_REL;
		btn_since[b] = '0;
	endfunction

	// Press a free button, or advance a held one through long and repeat
	function automatic void hold_or_press(input logic [1:0] b, input logic [31:0] now);
		logic [31:0] held;
		if (btn_phase[b] != PH_REL) begin
			held = now - btn_since[b];
			if (long_ms != 0 && btn_phase[b] == PH_PRS && held >= {16'd0, long_ms}) begin
				add_event(EV_LONG, b);
				btn_since[b] = now;
				btn_phase[b] = PH_LONG;
			end else if (repeat_ms != 0 && btn_phase[b][1] && held > {16'd0, repeat_ms}) begin
				add_event(EV_REPEAT, b);
				btn_since[b] = now;
				btn_phase[b] = PH_RPT;
			end
		end else begin
			release_button(b ^ 2'd1);
			add_event(EV_PRESS, b);
			btn_since[b] = now;
			btn_phase[b] = PH_PRS;
		end
	endfunction

	// High test, then low test, then release band
	function automatic void eval_axis(input int a, input int hi, input int lo, input int band,
			input logic [1:0] hi_btn, input logic [31:0] now);
		logic [1:0] lo_btn;
		lo_btn = hi_btn + 2'd1;
		if (a > hi)
			hold_or_press(hi_btn, now);
		else if (a < lo)
			hold_or_press(lo_btn, now);
		else if (a < hi - band && a > lo + band) begin
			release_button(hi_btn);
			release_button(lo_btn);
		end
	endfunction

	function automatic void predict_events(input tilt_req_t r);
		event_batch.delete();
		if (r.func) begin
			release_button(BTN_UP);
			release_button(BTN_DOWN);
			release_button(BTN_LEFT);
			release_button(BTN_RIGHT);
		end else if (r.present) begin
			eval_axis(int'(r.roll), int'(roll_up_thr), int'(roll_down_thr),
				int'(roll_band), BTN_UP, r.now);
			eval_axis(int'(r.pitch), int'(pitch_left_thr), int'(pitch_rgt_thr),
				int'(pitch_band), BTN_LEFT, r.now);
		end
		if (event_batch.size() > 0)
			event_batch[event_batch.size() - 1].last = 1'b1;
		foreach (event_batch[i])
			expected_events.push_back(event_batch[i]);
	endfunction

	function automatic void push_sample(input logic func, input logic present, input int roll,
			input int pitch, input logic [31:0] now);
		tilt_req_t r;
		r.func = func;
		r.present = present;
		r.roll = roll[12:0];
		r.pitch = pitch[12:0];
		r.now = now;
		pending_requests.push_back(r);
	endfunction

	function automatic int clamp_angle(input int a);
		if (a > ANGLE_MAX)
			return ANGLE_MAX;
		if (a < -ANGLE_MAX)
			return -ANGLE_MAX;
		return a;
	endfunction

	// Angle choice sticks to a region most of the time so buttons get held
	function automatic int pick_angle(inout int region, input int hi, input int lo,
			input int band);
		int a;
		int low;
		int high;
		if ($urandom_range(0, 99) < 40)
			region = $urandom_range(0, 4);
		case (region)
			0: a = hi + 1 + int'($urandom_range(0, 200));
			1: a = lo - 1 - int'($urandom_range(0, 200));
			2: begin
				low = lo + band + 1;
				high = hi - band - 1;
				if (low <= high)
					a = low + int'($urandom_range(0, high - low));
				else
					a = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
			end
			3: a = hi - int'($urandom_range(0, band));
			default: a = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
		endcase
		return clamp_angle(a);
	endfunction

	function automatic void queue_random_requests(input int count);
		int pick;
		int roll;
		int pitch;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				gen_now = $urandom;
			else
				gen_now = gen_now + $urandom_range(0, 120);
			roll = pick_angle(roll_region, int'(roll_up_thr), int'(roll_down_thr),
				int'(roll_band));
			pitch = pick_angle(pitch_region, int'(pitch_left_thr), int'(pitch_rgt_thr),
				int'(pitch_band));
			pick = $urandom_range(0, 99);
			if (pick < 6)
				push_sample(1'b1, 1'($urandom_range(0, 1)), roll, pitch, gen_now);
			else if (pick < 14)
				push_sample(1'b0, 1'b0, roll, pitch, gen_now);
			else
				push_sample(1'b0, 1'b1, roll, pitch, gen_now);
		end
	endfunction

	task automatic write_reg(input logic [2:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value[15:0];
		case (idx)
			CFG_ROLL_UP:    roll_up_thr = value[12:0];
			CFG_ROLL_DOWN:  roll_down_thr = value[12:0];
			CFG_ROLL_BAND:  roll_band = value[11:0];
			CFG_PITCH_LEFT: pitch_left_thr = value[12:0];
			CFG_PITCH_RGT:  pitch_rgt_thr = value[12:0];
			CFG_PITCH_BAND: pitch_band = value[11:0];
			CFG_LONG_MS:    long_ms = value[15:0];
			CFG_REPEAT_MS:  repeat_ms = value[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int up, input int down, input int rband, input int left,
			input int rgt, input int pband, input int lms, input int rms);
		write_reg(CFG_ROLL_UP, up);
		write_reg(CFG_ROLL_DOWN, down);
		write_reg(CFG_ROLL_BAND, rband);
		write_reg(CFG_PITCH_LEFT, left);
		write_reg(CFG_PITCH_RGT, rgt);
		write_reg(CFG_PITCH_BAND, pband);
		write_reg(CFG_LONG_MS, lms);
		write_reg(CFG_REPEAT_MS, rms);
	endtask

	// Wait until every request is taken and every event checked, then let the pipe settle
	task automatic drain();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_events.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Request driver
	tilt_req_t cur_req;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				predict_events(cur_req);
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					cur_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {6'd0, cur_req.now, cur_req.pitch, cur_req.roll};
					s_tuser <= {cur_req.present, cur_req.func};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_kick)
			hold_cnt <= 400;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
	end

	// Event monitor and scoreboard
	always @(posedge clk or negedge arst_n) begin : event_check
		button_event_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t unexpected event: kind %0d btn %0d last %0b",
							$realtime, m_tuser, m_tdata[1:0], m_tlast);
				end else begin
					want = expected_events.pop_front();
					if (m_tuser !== want.kind || m_tdata[1:0] !== want.btn
							|| m_tlast !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t mismatch: want kind %0d btn %0d last %0b, got kind %0d btn %0d last %0b",
								$realtime, want.kind, want.btn, want.last,
								m_tuser, m_tdata[1:0], m_tlast);
					end
				end
			end
			if (hold_cnt != 0)
				m_tready <= 1'b0;
			else
				m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// Stimulus sequence
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at reset defaults
		push_sample(1'b1, 1'b0, 0, 0, 32'd900);         // release all with nothing held
		push_sample(1'b0, 1'b0, 2880, 2880, 32'd950);   // sensor absent
		push_sample(1'b0, 1'b1, 2880, -2880, 32'd1000); // press up and right
		push_sample(1'b0, 1'b1, -2880, 2880, 32'd1050); // both axes flip: six events
		push_sample(1'b0, 1'b1, -200, 400, 32'd1349);   // one short of long
		push_sample(1'b0, 1'b1, -200, 400, 32'd1350);   // long on both
		push_sample(1'b0, 1'b1, -200, 400, 32'd1500);   // gap equal, no repeat
		push_sample(1'b0, 1'b1, -200, 400, 32'd1501);   // repeat on both
		push_sample(1'b0, 1'b1, 100, 200, 32'd1550);    // roll in dead zone, pitch released
		push_sample(1'b0, 1'b1, 0, 0, 32'd1600);        // release from long/repeat
		push_sample(1'b1, 1'b0, 0, 0, 32'd1650);
		push_sample(1'b0, 1'b1, 129, -321, 32'hFFFF_FF00);
		push_sample(1'b0, 1'b1, 300, -400, 32'h0000_002C); // timer wraps, long
		push_sample(1'b1, 1'b1, 2880, 2880, 32'h0000_0100); // release all, angles ignored
		push_sample(1'b0, 1'b1, 128, 320, 32'h0000_0200);   // exactly on thresholds
		push_sample(1'b0, 1'b1, -129, 321, 32'h0000_0300);
		push_sample(1'b0, 1'b1, 79, 240, 32'h0000_0400);    // roll just inside band
		push_sample(1'b0, 1'b1, 79, 239, 32'h0000_0500);    // pitch just inside band
		push_sample(1'b1, 1'b0, -2880, -2880, 32'h7FFF_FFFF);
		drain();

		gen_now = $urandom;

		// Widest thresholds and bands, long and repeat disabled
		set_config(2880, -2880, 2880, 2880, -2880, 2880, 0, 0);
		queue_random_requests(20);
		drain();

		// Inverted thresholds, no band, longest timers
		set_config(-2880, 2880, 0, -2880, 2880, 0, 65535, 65535);
		queue_random_requests(20);
		drain();

		// Tight thresholds, shortest timers
		set_config(16, -16, 8, 16, -16, 8, 1, 1);
		queue_random_requests(40);
		drain();

		// Defaults, no idling on either side
		set_config(128, -128, 48, 320, -320, 80, 300, 150);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		queue_random_requests(60);
		drain();

		// Receiver stalls long while the sender keeps offering
		queue_random_requests(60);
		@(posedge clk);
		hold_kick <= 1'b1;
		@(posedge clk);
		hold_kick <= 1'b0;
		drain();
		src_idle_pct = 29;
		snk_idle_pct = 29;

		// Random settings
		repeat (4) begin
			if ($urandom_range(0, 3) == 0)
				set_config(int'($urandom_range(0, 5760)) - 2880,
					int'($urandom_range(0, 5760)) - 2880, $urandom_range(0, 2880),
					int'($urandom_range(0, 5760)) - 2880,
					int'($urandom_range(0, 5760)) - 2880, $urandom_range(0, 2880),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			else
				set_config($urandom_range(0, 800), -int'($urandom_range(0, 800)),
					$urandom_range(0, 300), $urandom_range(0, 800),
					-int'($urandom_range(0, 800)), $urandom_range(0, 300),
					$urandom_range(0, 600), $urandom_range(0, 400));
			queue_random_requests(60);
			drain();
		end

		if (mismatch_count == 0 && expected_events.size() == 0)
			$display("tilt_to_dpad_button_events_top test passed");
		else
			$display("tilt_to_dpad_button_events_top test failed");
		$finish;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("tilt_to_dpad_button_events_top test failed");
		$finish;
	end

endmodule

// File: tilt_to_dpad_button_events_top.f
rtl/tdbe_pkg.sv
rtl/tdbe_cfg.sv
rtl/tdbe_axis.sv
rtl/tdbe_evq.sv
rtl/tilt_to_dpad_button_events_top.sv
rtl/tdbe_chk.sv
sim/tilt_to_dpad_button_events_top_tb.sv
